[hdl/tkbs_pkg.sv]
// Shared types and constants for the top-K box selector.
// No dependencies; every other file in hdl/ depends on this package.
package tkbs_pkg;

   localparam int COORD_W = 32;
   localparam int SCORE_W = 16;
   localparam int LIMIT_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } box_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      box_type            box;
   } entry_type;

   // Per-cycle command to every cell of the chain.
   typedef struct packed {
      logic insert;   // place the incoming box in score order
      logic shift;    // move every entry one cell toward the head
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_DRAIN = 2'b10
   } state_type;

endpackage

[hdl/tkbs_if.sv]
// Channel interfaces for the top-K box selector: box input, result output
// and the keep-limit write port. Depends on tkbs_pkg.

interface tkbs_req_if;
   logic                         valid;
   logic                         ready;
   logic [tkbs_pkg::COORD_W-1:0] box_x0;
   logic [tkbs_pkg::COORD_W-1:0] box_y0;
   logic [tkbs_pkg::COORD_W-1:0] box_x1;
   logic [tkbs_pkg::COORD_W-1:0] box_y1;
   logic [tkbs_pkg::SCORE_W-1:0] box_score;
   logic                         set_end;
   modport source (output valid, box_x0, box_y0, box_x1, box_y1, box_score, set_end,
                   input ready);
   modport sink   (input valid, box_x0, box_y0, box_x1, box_y1, box_score, set_end,
                   output ready);
endinterface

interface tkbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tkbs_pkg::COORD_W-1:0] out_x0;
   logic [tkbs_pkg::COORD_W-1:0] out_y0;
   logic [tkbs_pkg::COORD_W-1:0] out_x1;
   logic [tkbs_pkg::COORD_W-1:0] out_y1;
   logic                         run_end;
   modport source (output valid, out_x0, out_y0, out_x1, out_y1, run_end,
                   input ready);
   modport sink   (input valid, out_x0, out_y0, out_x1, out_y1, run_end,
                   output ready);
endinterface

interface tkbs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tkbs_pkg::LIMIT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hdl/tkbs_cell.sv]
// One slot of the sorted box chain: holds a score and its box.
// Depends on tkbs_pkg.
module tkbs_cell (
   input  logic                   clock,
   input  tkbs_pkg::cell_ctl_type ctl,
   input  tkbs_pkg::entry_type    new_entry,
   input  tkbs_pkg::entry_type    left_entry,
   input  logic                   left_disp,
   input  tkbs_pkg::entry_type    right_entry,
   input  logic                   valid,
   output tkbs_pkg::entry_type    entry,
   output logic                   disp
);
   import tkbs_pkg::*;

   entry_type entry_ff, entry_in;

   // Equal scores stay ahead of the newcomer.
   assign disp = !valid || (entry_ff.score < new_entry.score);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = right_entry;
      end else if (ctl.insert && disp) begin
         entry_in = left_disp ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[hdl/top_k_box_selector.sv]
// Top level of the top-K box selector: control, output register and cell chain.
// Depends on tkbs_pkg, tkbs_if (interfaces) and tkbs_cell.
//
// Usage:
//  - req_if carries one box per transfer (four coordinate words, a Q1.15
//    score, set_end). While collecting, a box is taken every cycle: each
//    transfer drops into a chain of MAX_KEEP cells kept sorted by score,
//    ties ranked by arrival.
//  - The transfer with set_end closes the set. The block then stops taking
//    boxes and drains min(keep_limit, kept) boxes from the head of the
//    chain, one per cycle unless rsp_if stalls, through a single output
//    register on rsp_if; run_end marks the last one. req_if is ready again
//    once the last result is loaded, or at once if none is emitted.
//  - The closing transfer moves control to S_DRAIN; the first result is then
//    loaded into the output register once that register is free, and is
//    offered on rsp_if from there.
//  - A stall on rsp_if holds the output register and freezes the chain;
//    nothing is lost. Once the last result is loaded, new boxes are taken
//    even while it still waits on rsp_if.
//  - csr_if writes keep_limit (7 bits, reset 64, saturated to MAX_KEEP).
//    It is always ready; write it only while the block is idle.
//  - Reset (synchronous, active high) empties the chain, clears the output
//    valid and restores keep_limit. No clearing pass is needed.
module top_k_box_selector #(
   parameter int MAX_KEEP = 64
) (
   input  logic      clock,
   input  logic      reset,
   tkbs_req_if.sink  req_if,
   tkbs_rsp_if.source rsp_if,
   tkbs_csr_if.sink  csr_if
);
   import tkbs_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEEP + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;     // boxes held in the chain
   logic [CNT_W-1:0]   remain_ff, remain_in;   // results still to emit
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               run_end_ff, run_end_in;
   box_type            rsp_box_ff, rsp_box_in;

   logic               accept;
   logic               step;
   logic [LIMIT_W-1:0] limit_sat;
   logic [CNT_W-1:0]   count_after;
   logic [CNT_W-1:0]   emit_n;
   cell_ctl_type       ctl;
   entry_type          new_entry;
   entry_type          cell_entry [MAX_KEEP];
   logic               cell_disp  [MAX_KEEP];

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   // Drain step: head of the chain moves into a free output register.
   assign step         = (state_ff == S_DRAIN) && (!rsp_valid_ff || rsp_if.ready);

   assign ctl.insert = accept;
   assign ctl.shift  = step;

   assign new_entry.score  = req_if.box_score;
   assign new_entry.box.x0 = req_if.box_x0;
   assign new_entry.box.y0 = req_if.box_y0;
   assign new_entry.box.x1 = req_if.box_x1;
   assign new_entry.box.y1 = req_if.box_y1;

   // ---- cell chain; head is index 0, highest score
   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == MAX_KEEP - 1) ? i : i + 1;
      logic cell_valid;
      assign cell_valid = (CNT_W'(i) < count_ff);
      tkbs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_entry  (new_entry),
         .left_entry ((i == 0) ? new_entry : cell_entry[LEFT]),
         .left_disp  ((i == 0) ? 1'b0 : cell_disp[LEFT]),
         .right_entry(cell_entry[RIGHT]),
         .valid      (cell_valid),
         .entry      (cell_entry[i]),
         .disp       (cell_disp[i])
      );
   end

   // ---- result count at set end
   assign limit_sat   = (limit_ff > LIMIT_W'(MAX_KEEP)) ? LIMIT_W'(MAX_KEEP) : limit_ff;
   // A box always finds a slot while the chain has room.
   assign count_after = (count_ff == CNT_W'(MAX_KEEP)) ? count_ff : count_ff + 1'b1;
   assign emit_n      = (CNT_W'(limit_sat) < count_after) ? CNT_W'(limit_sat) : count_after;

   assign csr_if.ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      run_end_in   = run_end_ff;
      rsp_box_in   = rsp_box_ff;

      if (csr_if.valid) begin
         limit_in = csr_if.data;
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_if.set_end) begin
                  count_in  = '0;
                  remain_in = emit_n;
                  if (emit_n != '0) begin
                     state_in = S_DRAIN;
                  end
               end else begin
                  count_in = count_after;
               end
            end
         end
         S_DRAIN: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               rsp_box_in   = cell_entry[0].box;
               run_end_in   = (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_end_ff <= run_end_in;
      rsp_box_ff <= rsp_box_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.out_x0  = rsp_box_ff.x0;
   assign rsp_if.out_y0  = rsp_box_ff.y0;
   assign rsp_if.out_x1  = rsp_box_ff.x1;
   assign rsp_if.out_y1  = rsp_box_ff.y1;
   assign rsp_if.run_end = run_end_ff;

   // ---- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEEP))
      else $error("chain count above capacity");

   a_drain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (remain_ff != '0))
      else $error("drain with nothing left to emit");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step && remain_ff == CNT_W'(1)) |=> (state_ff == S_IDLE) && rsp_valid_ff && run_end_ff)
      else $error("last result did not end the run");

   a_mid_not_end: assert property (@(posedge clock) disable iff (reset)
      (step && remain_ff != CNT_W'(1)) |=> rsp_valid_ff && !run_end_ff && (state_ff == S_DRAIN))
      else $error("run ended early");

endmodule
